/* rtl/core/psrs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the partitioned swap-remove set.
// Depends on nothing; every other file imports it.
package psrs_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ENTRY_IDS = 4096;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ID_W      = 12;
  localparam int ID_AW     = $clog2(ENTRY_IDS);
  localparam int LFSR_W    = 32;
  localparam int STEP_W    = $clog2(LFSR_W);
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 3;

  localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [CNT_W-1:0]  NO_SLOT   = {CNT_W{1'b1}};

  // command codes of an input beat
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_MARK    = 3'd2,
    CMD_NEXT    = 3'd3,
    CMD_PICK    = 3'd4,
    CMD_SHUFFLE = 3'd5
  } cmd_e;

  // status codes of an output beat
  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_EMPTY       = 3'd1,
    STAT_FULL        = 3'd2,
    STAT_PRESENT     = 3'd3,
    STAT_NOT_PRESENT = 3'd4
  } status_e;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_ID_RD,
    OP_INS,
    OP_SW_RA,
    OP_SW_RB,
    OP_SW_W1,
    OP_SW_W2,
    OP_UP_INC,
    OP_UP_DEC,
    OP_MK,
    OP_RM_A,
    OP_RM_B,
    OP_RM_END,
    OP_NX,
    OP_RD_US,
    OP_RD_REM,
    OP_RES,
    OP_DRAW_PICK,
    OP_DRAW_SHUF,
    OP_SH_INIT,
    OP_SH_SET,
    OP_SH_DEC,
    OP_SH_END,
    OP_OUT
  } op_e;

  // controller states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_SW_RA,
    S_SW_RB,
    S_SW_W1,
    S_SW_W2,
    S_UP_INC,
    S_UP_DEC,
    S_RM_B,
    S_RM_END,
    S_RD_US,
    S_DIV,
    S_RD_REM,
    S_RES,
    S_DRAW_SH,
    S_SH_SET,
    S_SH_DEC,
    S_SH_END,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic present;
    logic p_lt_us;
    logic held_zero;
    logic held_full;
    logic held_gt1;
    logic pa_is_one;
    logic div_done;
    logic clr_last;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/core/partitioned_swap_remove_set.sv */
`timescale 1ns / 1ps
// Top level of the partitioned swap-remove set: controller plus datapath.
// Depends on psrs_pkg, psrs_ctrl and psrs_dp (which holds psrs_mod).

// One input beat at a time, one output beat per input beat. After reset the
// id-to-slot map is cleared one entry per cycle, all 4096 entries, with the
// input stalled. Errors, empty-set answers, unused commands, shuffles of fewer
// than two entries and marking an entry that is already tested go straight to
// the result; insert and mark tested do one swap; remove does one swap, or two
// when the entry sits in the tested part; next to test reads one slot; random
// pick waits on the bit-serial remainder unit; shuffle of n held entries does
// n-1 steps, each step one remainder draw plus one swap (two reads, two writes)
// through the slot memory. The next beat is
// taken the cycle after a result enters the output register, even if that
// result is still stalled; a result waits while the previous one is stalled.
module partitioned_swap_remove_set (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          random_seed_we_i,
  input  logic [psrs_pkg::LFSR_W-1:0]   random_seed_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [psrs_pkg::CMD_W-1:0]    command_i,
  input  logic [psrs_pkg::ID_W-1:0]     entry_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psrs_pkg::STAT_W-1:0]   status_o,
  output logic [psrs_pkg::ID_W-1:0]     result_id_o,
  output logic [psrs_pkg::CNT_W-1:0]    entry_count_o,
  output logic [psrs_pkg::CNT_W-1:0]    tested_count_o
);
  import psrs_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  psrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // storage and arithmetic
  psrs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .random_seed_we_i (random_seed_we_i),
    .random_seed_i    (random_seed_i),
    .command_i        (command_i),
    .entry_id_i       (entry_id_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .result_id_o      (result_id_o),
    .entry_count_o    (entry_count_o),
    .tested_count_o   (tested_count_o)
  );

endmodule

/* rtl/core/psrs_mod.sv */
`timescale 1ns / 1ps
// Restoring remainder unit: one quotient bit per cycle over a 32-bit word.
// Depends on psrs_pkg.
module psrs_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [psrs_pkg::LFSR_W-1:0]  dividend_i,
  input  logic [psrs_pkg::CNT_W-1:0]   divisor_i,
  output logic [psrs_pkg::CNT_W-1:0]   rem_o,
  output logic                         done_o
);
  import psrs_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [LFSR_W-1:0] num_q;
  logic [CNT_W-1:0]  rem_q, dsr_q, rem_d;
  logic [CNT_W:0]    trial;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q, num_q[LFSR_W-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = CNT_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[CNT_W-1:0];
    end
  end

  // control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == {STEP_W{1'b1}}) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // operand and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[LFSR_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

/* rtl/core/psrs_dp.sv */
`timescale 1ns / 1ps
// Datapath: slot and id memories, counters, generator, remainder unit, output register.
// Depends on psrs_pkg and psrs_mod.
module psrs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psrs_pkg::ctrl_t               ctrl_i,
  output psrs_pkg::stat_t               stat_o,
  input  logic                          random_seed_we_i,
  input  logic [psrs_pkg::LFSR_W-1:0]   random_seed_i,
  input  logic [psrs_pkg::CMD_W-1:0]    command_i,
  input  logic [psrs_pkg::ID_W-1:0]     entry_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psrs_pkg::STAT_W-1:0]   status_o,
  output logic [psrs_pkg::ID_W-1:0]     result_id_o,
  output logic [psrs_pkg::CNT_W-1:0]    entry_count_o,
  output logic [psrs_pkg::CNT_W-1:0]    tested_count_o
);
  import psrs_pkg::*;

  logic [ID_W-1:0]   slot_mem [CAPACITY];
  logic [CNT_W-1:0]  id_mem   [ENTRY_IDS];

  logic [CNT_W-1:0]  held_q, ustart_q;
  logic [LFSR_W-1:0] lfsr_q, lfsr_nx;
  logic [ID_AW-1:0]  clr_q;
  logic              out_valid_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [ID_W-1:0]   id_q, ida_q, idb_q, res_q, slot_rd_q;
  logic [CNT_W-1:0]  id_rd_q;
  logic [SLOT_W-1:0] pa_q, pb_q;
  logic [STAT_W-1:0] status_q;
  logic [ID_W-1:0]   result_q;
  logic [CNT_W-1:0]  count_q, tested_q;

  logic              slot_we, id_we;
  logic [SLOT_W-1:0] slot_wa, slot_ra;
  logic [ID_W-1:0]   slot_wd;
  logic [ID_AW-1:0]  id_wa;
  logic [CNT_W-1:0]  id_wd;

  logic              div_start, div_done;
  logic [CNT_W-1:0]  div_dsr, div_rem;

  // next generator word
  assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);

  // memory port selection
  always_comb begin
    slot_we = 1'b0;
    slot_wa = pa_q;
    slot_wd = id_q;
    id_we   = 1'b0;
    id_wa   = id_q[ID_AW-1:0];
    id_wd   = NO_SLOT;
    slot_ra = pa_q;
    unique case (ctrl_i.op)
      OP_CLEAR: begin
        id_we = 1'b1;
        id_wa = clr_q;
      end
      OP_INS: begin
        slot_we = 1'b1;
        slot_wa = held_q[SLOT_W-1:0];
        id_we   = 1'b1;
        id_wd   = held_q;
      end
      OP_SW_RB: slot_ra = pb_q;
      OP_SW_W1: begin
        slot_we = 1'b1;
        slot_wa = pa_q;
        slot_wd = slot_rd_q;
        id_we   = 1'b1;
        id_wa   = ida_q[ID_AW-1:0];
        id_wd   = CNT_W'(pb_q);
      end
      OP_SW_W2: begin
        slot_we = 1'b1;
        slot_wa = pb_q;
        slot_wd = ida_q;
        id_we   = 1'b1;
        id_wa   = idb_q[ID_AW-1:0];
        id_wd   = CNT_W'(pa_q);
      end
      OP_RM_END: id_we = 1'b1;
      OP_RD_US:  slot_ra = ustart_q[SLOT_W-1:0];
      OP_RD_REM: slot_ra = div_rem[SLOT_W-1:0];
      default: ;
    endcase
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[slot_ra];
  end

  // id-to-slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[id_wa] <= id_wd;
    end
    id_rd_q <= id_mem[id_q[ID_AW-1:0]];
  end

  // remainder unit operands
  assign div_start = (ctrl_i.op == OP_DRAW_PICK) || (ctrl_i.op == OP_DRAW_SHUF);
  assign div_dsr   = (ctrl_i.op == OP_DRAW_PICK) ? held_q : (CNT_W'(pa_q) + 1'b1);

  psrs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lfsr_nx),
    .divisor_i  (div_dsr),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // control state: counts, generator, clear pointer, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      ustart_q    <= '0;
      lfsr_q      <= LFSR_W'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result beat replaces the one leaving this cycle
      if (ctrl_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (random_seed_we_i) begin
        lfsr_q <= (random_seed_i == '0) ? LFSR_W'(1) : random_seed_i;
      end else if (div_start) begin
        lfsr_q <= lfsr_nx;
      end
      unique case (ctrl_i.op)
        OP_CLEAR:  clr_q <= clr_q + 1'b1;
        OP_INS:    held_q <= held_q + 1'b1;
        OP_UP_INC: ustart_q <= ustart_q + 1'b1;
        OP_UP_DEC: ustart_q <= ustart_q - 1'b1;
        OP_RM_END: held_q <= held_q - 1'b1;
        OP_NX: begin
          if (ustart_q >= held_q) begin
            ustart_q <= '0;
          end
        end
        OP_SH_END: ustart_q <= '0;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LATCH: begin
        id_q  <= entry_id_i;
        cmd_q <= command_i;
        res_q <= '0;
      end
      OP_INS: begin
        pa_q <= held_q[SLOT_W-1:0];
        pb_q <= ustart_q[SLOT_W-1:0];
      end
      OP_SW_RB: ida_q <= slot_rd_q;
      OP_SW_W1: idb_q <= slot_rd_q;
      OP_MK: begin
        pa_q <= id_rd_q[SLOT_W-1:0];
        pb_q <= ustart_q[SLOT_W-1:0];
      end
      OP_RM_A: begin
        pa_q <= id_rd_q[SLOT_W-1:0];
        pb_q <= SLOT_W'(ustart_q - 1'b1);
      end
      OP_UP_DEC: pa_q <= pb_q;
      OP_RM_B:   pb_q <= SLOT_W'(held_q - 1'b1);
      OP_RES:    res_q <= slot_rd_q;
      OP_SH_INIT: pa_q <= SLOT_W'(held_q - 1'b1);
      OP_SH_SET: pb_q <= div_rem[SLOT_W-1:0];
      OP_SH_DEC: pa_q <= pa_q - 1'b1;
      OP_OUT: begin
        status_q <= ctrl_i.status;
        result_q <= res_q;
        count_q  <= held_q;
        tested_q <= ustart_q;
      end
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.present   = (id_rd_q != NO_SLOT);
    stat_o.p_lt_us   = (id_rd_q < ustart_q);
    stat_o.held_zero = (held_q == '0);
    stat_o.held_full = (held_q >= CNT_W'(CAPACITY));
    stat_o.held_gt1  = (held_q > CNT_W'(1));
    stat_o.pa_is_one = (pa_q == SLOT_W'(1));
    stat_o.div_done  = div_done;
    stat_o.clr_last  = (clr_q == {ID_AW{1'b1}});
    stat_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_id_o    = result_q;
  assign entry_count_o  = count_q;
  assign tested_count_o = tested_q;

endmodule

/* rtl/core/psrs_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences lookups, swaps, draws and the reset clearing pass.
// Depends on psrs_pkg.
module psrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  psrs_pkg::stat_t stat_i,
  output psrs_pkg::ctrl_t ctrl_o
);
  import psrs_pkg::*;

  state_e  state_q, state_d, ret_q, ret_d;
  status_e sts_q, sts_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_DONE;
      sts_q   <= STAT_OK;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      sts_q   <= sts_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d       = state_q;
    ret_d         = ret_q;
    sts_d         = sts_q;
    ctrl_o.op     = OP_NONE;
    ctrl_o.status = sts_q;
    in_stall_o    = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.op = OP_CLEAR;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.op = OP_LATCH;
          sts_d     = STAT_OK;
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        ctrl_o.op = OP_ID_RD;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_DONE;
        case (stat_i.cmd)
          CMD_INSERT: begin
            if (stat_i.present) begin
              sts_d = STAT_PRESENT;
            end else if (stat_i.held_full) begin
              sts_d = STAT_FULL;
            end else begin
              ctrl_o.op = OP_INS;
              ret_d     = S_UP_INC;
              state_d   = S_SW_RA;
            end
          end
          CMD_REMOVE: begin
            if (!stat_i.present) begin
              sts_d = STAT_NOT_PRESENT;
            end else begin
              ctrl_o.op = OP_RM_A;
              if (stat_i.p_lt_us) begin
                ret_d   = S_UP_DEC;
                state_d = S_SW_RA;
              end else begin
                state_d = S_RM_B;
              end
            end
          end
          CMD_MARK: begin
            if (!stat_i.present) begin
              sts_d = STAT_NOT_PRESENT;
            end else if (!stat_i.p_lt_us) begin
              ctrl_o.op = OP_MK;
              ret_d     = S_UP_INC;
              state_d   = S_SW_RA;
            end
          end
          CMD_NEXT: begin
            if (stat_i.held_zero) begin
              sts_d = STAT_EMPTY;
            end else begin
              ctrl_o.op = OP_NX;
              state_d   = S_RD_US;
            end
          end
          CMD_PICK: begin
            if (stat_i.held_zero) begin
              sts_d = STAT_EMPTY;
            end else begin
              ctrl_o.op = OP_DRAW_PICK;
              state_d   = S_DIV;
            end
          end
          CMD_SHUFFLE: begin
            if (stat_i.held_gt1) begin
              ctrl_o.op = OP_SH_INIT;
              state_d   = S_DRAW_SH;
            end
          end
          default: ;
        endcase
      end
      // swap of slots pa and pb through S_SW_RA, S_SW_RB, S_SW_W1 and S_SW_W2
      S_SW_RA: begin
        ctrl_o.op = OP_SW_RA;
        state_d   = S_SW_RB;
      end
      S_SW_RB: begin
        ctrl_o.op = OP_SW_RB;
        state_d   = S_SW_W1;
      end
      S_SW_W1: begin
        ctrl_o.op = OP_SW_W1;
        state_d   = S_SW_W2;
      end
      S_SW_W2: begin
        ctrl_o.op = OP_SW_W2;
        state_d   = ret_q;
      end
      S_UP_INC: begin
        ctrl_o.op = OP_UP_INC;
        state_d   = S_DONE;
      end
      S_UP_DEC: begin
        ctrl_o.op = OP_UP_DEC;
        state_d   = S_RM_B;
      end
      S_RM_B: begin
        ctrl_o.op = OP_RM_B;
        ret_d     = S_RM_END;
        state_d   = S_SW_RA;
      end
      S_RM_END: begin
        ctrl_o.op = OP_RM_END;
        state_d   = S_DONE;
      end
      S_RD_US: begin
        ctrl_o.op = OP_RD_US;
        state_d   = S_RES;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = (stat_i.cmd == CMD_PICK) ? S_RD_REM : S_SH_SET;
        end
      end
      S_RD_REM: begin
        ctrl_o.op = OP_RD_REM;
        state_d   = S_RES;
      end
      S_RES: begin
        ctrl_o.op = OP_RES;
        state_d   = S_DONE;
      end
      S_DRAW_SH: begin
        ctrl_o.op = OP_DRAW_SHUF;
        state_d   = S_DIV;
      end
      S_SH_SET: begin
        ctrl_o.op = OP_SH_SET;
        ret_d     = S_SH_DEC;
        state_d   = S_SW_RA;
      end
      S_SH_DEC: begin
        if (stat_i.pa_is_one) begin
          state_d = S_SH_END;
        end else begin
          ctrl_o.op = OP_SH_DEC;
          state_d   = S_DRAW_SH;
        end
      end
      S_SH_END: begin
        ctrl_o.op = OP_SH_END;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          ctrl_o.op = OP_OUT;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench of partitioned_swap_remove_set: directed rows, then random command
// streams checked beat by beat against a behavioral copy of the slot set.
// Depends on psrs_pkg and the partitioned_swap_remove_set RTL only.
module tb;
  import psrs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   result_id;
    logic [CNT_W-1:0]  entry_count;
    logic [CNT_W-1:0]  tested_count;
  } set_answer_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    bit               typed;
    set_answer_t      ans;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                random_seed_we_i = 1'b0;
  logic [LFSR_W-1:0]   random_seed_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [ID_W-1:0]     entry_id_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [ID_W-1:0]     result_id_o;
  logic [CNT_W-1:0]    entry_count_o;
  logic [CNT_W-1:0]    tested_count_o;

  // copy of the set state
  logic [ID_W-1:0]     slot_of_set [CAPACITY];
  logic [CNT_W-1:0]    slot_of_id [ENTRY_IDS];
  logic [CNT_W-1:0]    held_n;
  logic [CNT_W-1:0]    boundary_n;
  logic [LFSR_W-1:0]   gen_word;

  set_answer_t         pending_answers[$];
  stim_row_t           directed_rows[$];
  int                  tx_gap_pct = 10;
  int                  rx_stall_pct = 69;
  bit                  failed = 1'b0;

  always #5 clk_i = ~clk_i;

  partitioned_swap_remove_set dut (.*);

  function automatic logic [CNT_W-1:0] draw_below(int span);
    logic low;
    low = gen_word[0];
    gen_word = gen_word >> 1;
    if (low) gen_word = gen_word ^ LFSR_MASK;
    return CNT_W'(gen_word % span);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [ID_W-1:0] ida, idb;
    ida = slot_of_set[a];
    idb = slot_of_set[b];
    slot_of_id[ida] = CNT_W'(b);
    slot_of_id[idb] = CNT_W'(a);
    slot_of_set[a] = idb;
    slot_of_set[b] = ida;
  endfunction

  function automatic void move_to_tested(logic [ID_W-1:0] id);
    if (slot_of_id[id] >= boundary_n) begin
      swap_slots(slot_of_id[id], boundary_n);
      boundary_n++;
    end
  endfunction

  // advance the set copy by one command and return its answer
  function automatic set_answer_t apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
    set_answer_t a;
    bit present;
    present = slot_of_id[id] != NO_SLOT;
    a.status = STAT_OK;
    a.result_id = '0;
    case (cmd)
      CMD_INSERT: begin
        if (present) a.status = STAT_PRESENT;
        else if (held_n >= CAPACITY) a.status = STAT_FULL;
        else begin
          slot_of_set[held_n] = id;
          slot_of_id[id] = held_n;
          held_n++;
          move_to_tested(id);
        end
      end
      CMD_REMOVE: begin
        if (!present) a.status = STAT_NOT_PRESENT;
        else begin
          if (slot_of_id[id] < boundary_n) begin
            swap_slots(slot_of_id[id], boundary_n - 1);
            boundary_n--;
          end
          swap_slots(slot_of_id[id], held_n - 1);
          held_n--;
          slot_of_id[id] = NO_SLOT;
        end
      end
      CMD_MARK: begin
        if (!present) a.status = STAT_NOT_PRESENT;
        else move_to_tested(id);
      end
      CMD_NEXT: begin
        if (held_n == 0) a.status = STAT_EMPTY;
        else begin
          if (boundary_n >= held_n) boundary_n = '0;
          a.result_id = slot_of_set[boundary_n];
        end
      end
      CMD_PICK: begin
        if (held_n == 0) a.status = STAT_EMPTY;
        else a.result_id = slot_of_set[draw_below(held_n)];
      end
      CMD_SHUFFLE: begin
        if (held_n > 1) begin
          for (int i = held_n - 1; i >= 1; i--) swap_slots(i, draw_below(i + 1));
          boundary_n = '0;
        end
      end
      default: ;
    endcase
    a.entry_count = held_n;
    a.tested_count = boundary_n;
    return a;
  endfunction

  // drive one command beat; valid stays high until the next beat or a gap
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, bit typed,
                              set_answer_t typed_ans);
    set_answer_t a;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    entry_id_i <= id;
    a = apply_command(cmd, id);
    pending_answers.insert(pending_answers.size(), typed ? typed_ans : a);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain outstanding answers, then load a new seed
  task automatic load_seed(logic [LFSR_W-1:0] seed);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    random_seed_we_i <= 1'b1;
    random_seed_i <= seed;
    @(posedge clk_i);
    random_seed_we_i <= 1'b0;
    gen_word = (seed == 0) ? 32'd1 : seed;
  endtask

  function automatic logic [ID_W-1:0] choose_id(bit held_bias);
    if (held_bias && held_n != 0) return slot_of_set[$urandom_range(held_n - 1)];
    if ($urandom_range(1)) return ID_W'($urandom_range(63));
    return ID_W'($urandom_range(ENTRY_IDS - 1));
  endfunction

  // one random beat; mix depends on the phase
  task automatic random_command(int phase);
    int r;
    logic [CMD_W-1:0] cmd;
    set_answer_t none;
    none = '{default: '0};
    r = $urandom_range(99);
    if (phase == 2) cmd = (r < 80) ? CMD_INSERT : (r < 88) ? CMD_REMOVE : CMD_SPARE6;
    else if (phase == 3) cmd = (r < 60) ? CMD_REMOVE : (r < 70) ? CMD_INSERT : CMD_SPARE6;
    else cmd = CMD_SPARE6;
    if (cmd == CMD_SPARE6) begin
      r = $urandom_range(99);
      cmd = (r < 20) ? CMD_INSERT : (r < 35) ? CMD_REMOVE : (r < 55) ? CMD_MARK :
            (r < 75) ? CMD_NEXT : (r < 95) ? CMD_PICK : (r < 98) ? CMD_SHUFFLE :
            (r < 99) ? CMD_SPARE6 : CMD_SPARE7;
    end
    // keep shuffles of more than 32 entries rare, they walk every held slot
    if (cmd == CMD_SHUFFLE && held_n > 32 && $urandom_range(19) != 0) cmd = CMD_PICK;
    if (cmd == CMD_INSERT && phase == 2)
      send_command(cmd, ID_W'($urandom_range(ENTRY_IDS - 1)), 1'b0, none);
    else
      send_command(cmd, choose_id($urandom_range(3) != 0), 1'b0, none);
  endtask

  // receiver stall
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < rx_stall_pct);

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        set_answer_t e;
        e = pending_answers.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          failed = 1'b1;
        end
        if (result_id_o !== e.result_id) begin
          $error("result_id expected %0d actual %0d", e.result_id, result_id_o);
          failed = 1'b1;
        end
        if (entry_count_o !== e.entry_count) begin
          $error("entry_count expected %0d actual %0d", e.entry_count, entry_count_o);
          failed = 1'b1;
        end
        if (tested_count_o !== e.tested_count) begin
          $error("tested_count expected %0d actual %0d", e.tested_count, tested_count_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    set_answer_t none;
    bit shuffled_full;
    int n;
    none = '{default: '0};
    shuffled_full = 1'b0;
    foreach (slot_of_set[i]) slot_of_set[i] = '0;
    foreach (slot_of_id[i]) slot_of_id[i] = NO_SLOT;
    held_n = '0;
    boundary_n = '0;
    gen_word = 32'd1;

    // directed rows: typed answers where obvious, else predicted
    directed_rows = '{
      '{CMD_NEXT,    12'd0,    1, '{STAT_EMPTY, 0, 0, 0}},
      '{CMD_PICK,    12'd0,    1, '{STAT_EMPTY, 0, 0, 0}},
      '{CMD_REMOVE,  12'd0,    1, '{STAT_NOT_PRESENT, 0, 0, 0}},
      '{CMD_MARK,    12'd4095, 1, '{STAT_NOT_PRESENT, 0, 0, 0}},
      '{CMD_SHUFFLE, 12'd0,    1, '{STAT_OK, 0, 0, 0}},
      '{CMD_INSERT,  12'd0,    1, '{STAT_OK, 0, 1, 1}},
      '{CMD_INSERT,  12'd4095, 1, '{STAT_OK, 0, 2, 2}},
      '{CMD_INSERT,  12'd0,    1, '{STAT_PRESENT, 0, 2, 2}},
      '{CMD_NEXT,    12'd0,    1, '{STAT_OK, 0, 2, 0}},
      '{CMD_MARK,    12'd4095, 0, none},
      '{CMD_SHUFFLE, 12'd0,    0, none},
      '{CMD_NEXT,    12'd0,    0, none},
      '{CMD_PICK,    12'd0,    0, none},
      '{CMD_PICK,    12'd0,    0, none},
      '{CMD_SPARE6,  12'd4095, 0, none},
      '{CMD_SPARE7,  12'd0,    0, none},
      '{CMD_INSERT,  12'hAAA,  0, none},
      '{CMD_INSERT,  12'h555,  0, none},
      '{CMD_MARK,    12'h555,  0, none},
      '{CMD_REMOVE,  12'd4095, 0, none},
      '{CMD_REMOVE,  12'd0,    0, none},
      '{CMD_REMOVE,  12'd0,    0, none},
      '{CMD_REMOVE,  12'hAAA,  0, none},
      '{CMD_REMOVE,  12'h555,  0, none},
      '{CMD_INSERT,  12'd4095, 0, none}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_seed(32'hFFFF_FFFF);
    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].typed,
                   directed_rows[i].ans);

    // mixed traffic, sender gaps light, receiver stalls heavy
    load_seed(32'd1);
    for (n = 0; n < 250; n++) random_command(1);

    // fill to capacity, sender gaps heavy, receiver stalls light
    tx_gap_pct = 69;
    rx_stall_pct = 10;
    load_seed($urandom());
    n = 0;
    while (n < 100) begin
      random_command(2);
      if (held_n == CAPACITY) begin
        n++;
        if (!shuffled_full) begin
          send_command(CMD_SHUFFLE, '0, 1'b0, none);
          shuffled_full = 1'b1;
        end
      end
    end

    // drain, no idling
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    load_seed($urandom() | 32'h8000_0000);
    for (n = 0; n < 250; n++) random_command(3);

    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
